/* src/fos_pkg.sv */
package fos_pkg;

	// Field widths fixed by the stream format
	localparam int CMD_W    = 3;
	localparam int DATA_W   = 32;
	localparam int INDEX_W  = 10;
	localparam int CAP_W    = 11;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 11;

	// Capacity after reset
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH       = 3'd0,
		CMD_POP        = 3'd1,
		CMD_PEEK       = 3'd2,
		CMD_READ_BOT   = 3'd3,
		CMD_READ_TOP   = 3'd4,
		CMD_OPEN       = 3'd5,
		CMD_CLOSE_DISC = 3'd6,
		CMD_CLOSE_RET  = 3'd7
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK          = 3'd0,
		ST_OVERFLOW    = 3'd1,
		ST_UNDERFLOW   = 3'd2,
		ST_RANGE       = 3'd3,
		ST_FRAME_UNDER = 3'd4,
		ST_FRAME_OVER  = 3'd5
	} status_t;

	typedef enum logic {
		S_IDLE = 1'b0,
		S_EXEC = 1'b1
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic accept;   // input transfer this cycle: check, issue memory access
		logic finish;   // retire command: update frame registers, load result
	} ctrl_t;

endpackage

/* src/framed_operand_stack_unit.sv */
// Operand stack with call frames for a virtual-machine core. Each command on
// the input stream (push, pop, peek, read by index from frame bottom or top,
// open frame, close frame with or without a return word) yields one result:
// the word read, a status code and the current frame's item count. A failing
// command leaves all state unchanged. In its transfer cycle a command is
// checked and its access to the word memory or the saved-count memory is
// issued. The read data is registered; once the output register is free or
// being emptied, the command retires: the frame registers are updated and
// the result is loaded there. The next command is taken only after that,
// while a result may still wait there. Both memories start undefined and
// need no clearing pass after reset. The capacity register may be written
// only while no command is in progress.
module framed_operand_stack_unit #(
	parameter int STACK_WORDS = 1024,
	parameter int WORD_BITS   = 32,
	parameter int FRAME_DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// Capacity register
	input  logic                      cfg_we,
	input  logic [fos_pkg::CAP_W-1:0] cfg_wdata,
	// Command stream
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [47:0]               s_tdata,   // data_in[31:0], index[41:32], zero
	input  logic [2:0]                s_tuser,   // command[2:0]
	// Result stream
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [47:0]               m_tdata    // read_data[31:0], status[34:32],
	                                             // frame_item_count[45:35],
	                                             // is_empty[46], zero
);

	import fos_pkg::*;

	ctrl_t               ctrl;
	logic [DATA_W-1:0]   read_data;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  frame_item_count;
	logic                is_empty;

	fos_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.ctrl      (ctrl)
	);

	fos_dpath #(
		.STACK_WORDS (STACK_WORDS),
		.WORD_BITS   (WORD_BITS),
		.FRAME_DEPTH (FRAME_DEPTH)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.ctrl             (ctrl),
		.cfg_we           (cfg_we),
		.cfg_wdata        (cfg_wdata),
		.command          (cmd_t'(s_tuser)),
		.data_in          (s_tdata[31:0]),
		.index            (s_tdata[41:32]),
		.read_data        (read_data),
		.status           (status),
		.frame_item_count (frame_item_count),
		.is_empty         (is_empty)
	);

	// Pack the result
	assign m_tdata = {1'b0, is_empty, frame_item_count, status, read_data};

endmodule

/* src/fos_ram.sv */
module fos_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port; read data holds between reads
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/fos_ctrl.sv */
module fos_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	output fos_pkg::ctrl_t ctrl
);

	import fos_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   accept;
	logic   finish;

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				if (finish) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Outputs: take a command in idle, retire it once the result register is free
	always_comb begin
		in_ready = 1'b0;
		finish   = 1'b0;
		unique case (state_q)
			S_IDLE: in_ready = 1'b1;
			S_EXEC: finish = !out_valid_q || out_ready;
			default: in_ready = 1'b0;
		endcase
		accept = in_valid && in_ready;
	end

	assign ctrl.accept = accept;
	assign ctrl.finish = finish;
	assign out_valid   = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Hold the result until its transfer
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* src/fos_dpath.sv */
module fos_dpath #(
	parameter int STACK_WORDS = 1024,
	parameter int WORD_BITS   = 32,
	parameter int FRAME_DEPTH = 64
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  fos_pkg::ctrl_t                ctrl,
	input  logic                          cfg_we,
	input  logic [fos_pkg::CAP_W-1:0]     cfg_wdata,
	input  fos_pkg::cmd_t                 command,
	input  logic [fos_pkg::DATA_W-1:0]    data_in,
	input  logic [fos_pkg::INDEX_W-1:0]   index,
	output logic [fos_pkg::DATA_W-1:0]    read_data,
	output logic [fos_pkg::STATUS_W-1:0]  status,
	output logic [fos_pkg::COUNT_W-1:0]   frame_item_count,
	output logic                          is_empty
);

	import fos_pkg::*;

	localparam int PW  = $clog2(STACK_WORDS + 1);
	localparam int AW  = $clog2(STACK_WORDS);
	localparam int OW  = $clog2(FRAME_DEPTH + 1);
	localparam int FAW = $clog2(FRAME_DEPTH);
	localparam int KW  = (PW > CAP_W) ? PW : CAP_W;
	localparam int IW  = (PW > INDEX_W) ? PW : INDEX_W;
	localparam int XW  = (PW > COUNT_W) ? PW : COUNT_W;

	logic [CAP_W-1:0]     capacity_q;
	logic [PW-1:0]        items_q;
	logic [PW-1:0]        base_q;
	logic [OW-1:0]        open_q;
	cmd_t                 cmd_s1;
	status_t              status_s1;

	logic [KW-1:0]        cap_cfg;
	logic [KW-1:0]        cap_words;
	logic [KW-1:0]        cap;
	logic [PW-1:0]        top;
	logic [PW-1:0]        top_m1;
	logic                 full;
	logic                 empty;
	logic                 idx_bad;
	logic [IW-1:0]        idx_ext;
	logic [IW-1:0]        bot_addr;
	logic [IW-1:0]        top_addr;

	logic [WORD_BITS+DATA_W-1:0] din_ext;
	logic [WORD_BITS+DATA_W-1:0] rd_ext;
	logic [WORD_BITS-1:0] din_word;

	status_t              st;
	logic                 st_we;
	logic [AW-1:0]        st_waddr;
	logic                 st_re;
	logic [AW-1:0]        st_raddr;
	logic [WORD_BITS-1:0] st_rdata;
	logic                 sv_we;
	logic                 sv_re;
	logic [FAW-1:0]       sv_waddr;
	logic [FAW-1:0]       sv_raddr;
	logic [PW-1:0]        sv_rdata;

	logic                 ok_s1;
	logic [PW-1:0]        saved;
	logic [PW-1:0]        items_d;
	logic [PW-1:0]        base_d;
	logic [OW-1:0]        open_d;
	logic [DATA_W-1:0]    rd_word;
	logic [XW-1:0]        count_ext;

	// Effective capacity and frame bounds
	assign cap_cfg   = KW'(capacity_q);
	assign cap_words = KW'(STACK_WORDS);
	assign cap       = (cap_cfg > cap_words) ? cap_words : cap_cfg;
	assign top       = base_q + items_q;
	assign top_m1    = top - PW'(1);
	assign full      = KW'(top) >= cap;
	assign empty     = items_q == '0;
	assign idx_ext   = IW'(index);
	assign idx_bad   = idx_ext >= IW'(items_q);
	assign bot_addr  = IW'(base_q) + idx_ext;
	assign top_addr  = IW'(top_m1) - idx_ext;
	assign din_ext   = {{WORD_BITS{1'b0}}, data_in};
	assign din_word  = din_ext[WORD_BITS-1:0];
	assign sv_waddr  = open_q[FAW-1:0];
	assign sv_raddr  = open_q[FAW-1:0] - FAW'(1);

	// Check the command and issue its memory access
	always_comb begin
		st       = ST_OK;
		st_we    = 1'b0;
		st_waddr = top[AW-1:0];
		st_re    = 1'b0;
		st_raddr = top_m1[AW-1:0];
		sv_we    = 1'b0;
		sv_re    = 1'b0;
		unique case (command)
			CMD_PUSH: begin
				if (full) begin
					st = ST_OVERFLOW;
				end else begin
					st_we = ctrl.accept;
				end
			end
			CMD_POP: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end
			end
			CMD_PEEK: begin
				if (empty) begin
					st = ST_UNDERFLOW;
				end else begin
					st_re = ctrl.accept;
				end
			end
			CMD_READ_BOT: begin
				if (idx_bad) begin
					st = ST_RANGE;
				end else begin
					st_re    = ctrl.accept;
					st_raddr = bot_addr[AW-1:0];
				end
			end
			CMD_READ_TOP: begin
				if (idx_bad) begin
					st = ST_RANGE;
				end else begin
					st_re    = ctrl.accept;
					st_raddr = top_addr[AW-1:0];
				end
			end
			CMD_OPEN: begin
				if (open_q >= OW'(FRAME_DEPTH)) begin
					st = ST_FRAME_OVER;
				end else if (full) begin
					st = ST_OVERFLOW;
				end else begin
					sv_we = ctrl.accept;
				end
			end
			CMD_CLOSE_DISC: begin
				if (open_q == '0) begin
					st = ST_FRAME_UNDER;
				end else begin
					sv_re = ctrl.accept;
				end
			end
			CMD_CLOSE_RET: begin
				if (open_q == '0) begin
					st = ST_FRAME_UNDER;
				end else begin
					sv_re    = ctrl.accept;
					// Fill the return slot just below the closing frame
					st_we    = ctrl.accept && (base_q != '0);
					st_waddr = AW'(base_q - PW'(1));
				end
			end
			default: st = ST_OK;
		endcase
	end

	fos_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (STACK_WORDS)
	) u_words (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (din_word),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	fos_ram #(
		.WIDTH (PW),
		.DEPTH (FRAME_DEPTH)
	) u_saved (
		.clk   (clk),
		.we    (sv_we),
		.waddr (sv_waddr),
		.wdata (items_q + PW'(1)),
		.re    (sv_re),
		.raddr (sv_raddr),
		.rdata (sv_rdata)
	);

	// Retire: restore or advance the frame registers
	assign ok_s1 = status_s1 == ST_OK;
	assign saved = ((sv_rdata == '0) || (sv_rdata > base_q)) ? base_q : sv_rdata;

	always_comb begin
		items_d = items_q;
		base_d  = base_q;
		open_d  = open_q;
		if (ok_s1) begin
			unique case (cmd_s1)
				CMD_PUSH: items_d = items_q + PW'(1);
				CMD_POP:  items_d = items_q - PW'(1);
				CMD_OPEN: begin
					items_d = '0;
					base_d  = top + PW'(1);
					open_d  = open_q + OW'(1);
				end
				CMD_CLOSE_DISC: begin
					items_d = (saved == '0) ? '0 : saved - PW'(1);
					base_d  = base_q - saved;
					open_d  = open_q - OW'(1);
				end
				CMD_CLOSE_RET: begin
					items_d = saved;
					base_d  = base_q - saved;
					open_d  = open_q - OW'(1);
				end
				CMD_PEEK, CMD_READ_BOT, CMD_READ_TOP: items_d = items_q;
				default: items_d = items_q;
			endcase
		end
	end

	assign rd_ext    = {{DATA_W{1'b0}}, st_rdata};
	assign count_ext = XW'(items_d);

	// Zero the read word unless a read succeeded
	always_comb begin
		rd_word = '0;
		if (ok_s1 && (cmd_s1 == CMD_PEEK || cmd_s1 == CMD_READ_BOT
				|| cmd_s1 == CMD_READ_TOP)) begin
			rd_word = rd_ext[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
			items_q    <= '0;
			base_q     <= '0;
			open_q     <= '0;
		end else begin
			if (cfg_we) begin
				capacity_q <= cfg_wdata;
			end
			if (ctrl.finish) begin
				items_q <= items_d;
				base_q  <= base_d;
				open_q  <= open_d;
			end
		end
	end

	// Command and check result, held until retire
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			cmd_s1    <= command;
			status_s1 <= st;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (ctrl.finish) begin
			read_data        <= rd_word;
			status           <= status_s1;
			frame_item_count <= count_ext[COUNT_W-1:0];
			is_empty         <= items_d == '0;
		end
	end

endmodule

/* bench/framed_operand_stack_unit_tb.sv */
module framed_operand_stack_unit_tb;
	import fos_pkg::*;

	localparam int STACK_DEPTH      = 1024;
	localparam int FRAME_LIMIT      = 64;
	localparam int FILL_CAP         = 128;
	localparam int SETTLE_CYCLES    = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT      = 100000;

	typedef struct {
		logic [DATA_W-1:0]   read_data;
		status_t             status;
		logic [COUNT_W-1:0]  item_count;
		logic                empty;
	} stack_resp_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CAP_W-1:0]    cfg_wdata = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [47:0]         s_tdata   = '0;   // data_in[31:0], index[41:32], zero
	logic [2:0]          s_tuser   = '0;   // command[2:0]
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [47:0]         m_tdata;          // read_data[31:0], status[34:32],
	                                       // frame_item_count[45:35], is_empty[46]

	// Shadow copy of the stack state
	logic [DATA_W-1:0]   stack_mem [STACK_DEPTH];
	int unsigned         caller_counts [FRAME_LIMIT];
	int unsigned         cur_items;
	int unsigned         cur_base;
	int unsigned         frame_level;
	int unsigned         cap_setting;

	stack_resp_t         pending_responses [$];
	int unsigned         errors;
	int unsigned         commands_sent;
	int unsigned         responses_checked;
	int unsigned         status_seen [8];
	int unsigned         cycle_count;
	bit                  idle_enable;
	bit                  long_hold_req;
	int unsigned         long_hold_count;
	int unsigned         stall_left;

	framed_operand_stack_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_responses.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// Apply one command to the shadow state and return the response it must produce
	function automatic stack_resp_t predict_stack_response(cmd_t op, logic [DATA_W-1:0] word,
			logic [INDEX_W-1:0] idx);
		stack_resp_t r;
		int unsigned cap_eff;
		int unsigned top;
		int unsigned saved;
		r.read_data = '0;
		r.status = ST_OK;
		cap_eff = (cap_setting > STACK_DEPTH) ? STACK_DEPTH : cap_setting;
		top = cur_base + cur_items;
		case (op)
			CMD_PUSH: begin
				if (top >= cap_eff) begin
					r.status = ST_OVERFLOW;
				end else begin
					stack_mem[top] = word;
					cur_items++;
				end
			end
			CMD_POP: begin
				if (cur_items == 0) r.status = ST_UNDERFLOW;
				else cur_items--;
			end
			CMD_PEEK: begin
				if (cur_items == 0) r.status = ST_UNDERFLOW;
				else r.read_data = stack_mem[top - 1];
			end
			CMD_READ_BOT: begin
				if (idx >= cur_items) r.status = ST_RANGE;
				else r.read_data = stack_mem[cur_base + idx];
			end
			CMD_READ_TOP: begin
				if (idx >= cur_items) r.status = ST_RANGE;
				else r.read_data = stack_mem[top - 1 - idx];
			end
			CMD_OPEN: begin
				if (frame_level >= FRAME_LIMIT) begin
					r.status = ST_FRAME_OVER;
				end else if (top >= cap_eff) begin
					r.status = ST_OVERFLOW;
				end else begin
					// The caller's count includes the reserved return slot
					caller_counts[frame_level] = cur_items + 1;
					frame_level++;
					cur_base = top + 1;
					cur_items = 0;
				end
			end
			default: begin
				if (frame_level == 0) begin
					r.status = ST_FRAME_UNDER;
				end else begin
					frame_level--;
					saved = caller_counts[frame_level];
					if (saved == 0 || saved > cur_base) saved = cur_base;
					if (op == CMD_CLOSE_DISC) begin
						cur_base -= saved;
						cur_items = (saved == 0) ? 0 : saved - 1;
					end else begin
						if (cur_base > 0) stack_mem[cur_base - 1] = word;
						cur_base -= saved;
						cur_items = saved;
					end
				end
			end
		endcase
		r.item_count = cur_items[COUNT_W-1:0];
		r.empty = (cur_items == 0);
		return r;
	endfunction

	// Drive the sink ready: one long hold on request, short random stalls otherwise
	always @(posedge clk) begin
		if (long_hold_req) begin
			m_tready <= 1'b0;
			long_hold_count++;
			if (long_hold_count == LONG_HOLD_CYCLES) begin
				long_hold_req = 1'b0;
				long_hold_count = 0;
			end
		end else if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left--;
		end else if (idle_enable && $urandom_range(4) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 2);
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result transfer against the oldest prediction
	always @(posedge clk) begin : check_responses
		stack_resp_t want;
		if (arst_n && m_tvalid && m_tready) begin
			status_seen[m_tdata[34:32]]++;
			if (pending_responses.size() == 0) begin
				$error("result with no command outstanding: tdata=%h", m_tdata);
				errors++;
			end else begin
				want = pending_responses.pop_front();
				responses_checked++;
				if (m_tdata[31:0] !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[34:32] !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tdata[34:32]);
					errors++;
				end
				if (m_tdata[45:35] !== want.item_count) begin
					$error("frame_item_count: expected %0d, got %0d", want.item_count,
						m_tdata[45:35]);
					errors++;
				end
				if (m_tdata[46] !== want.empty) begin
					$error("is_empty: expected %0d, got %0d", want.empty, m_tdata[46]);
					errors++;
				end
			end
		end
	end

	// Offer one command, hold it until the transfer, then record its prediction
	task automatic send_command(cmd_t op, logic [DATA_W-1:0] word = '0,
			logic [INDEX_W-1:0] idx = '0);
		stack_resp_t r;
		if (idle_enable && $urandom_range(3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, idx, word};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		r = predict_stack_response(op, word, idx);
		pending_responses.insert(pending_responses.size(), r);
		commands_sent++;
	endtask

	// Stop offering and wait until every result is back and the block is quiet
	task automatic wait_for_responses();
		s_tvalid <= 1'b0;
		while (pending_responses.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_capacity(logic [CAP_W-1:0] value);
		wait_for_responses();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cap_setting = value;
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Close every open frame and pop the rest
	task automatic unwind_to_empty();
		while (frame_level != 0) send_command(CMD_CLOSE_DISC);
		while (cur_items != 0) send_command(CMD_POP);
	endtask

	task automatic test_basic_commands();
		// Error cases on an empty stack
		send_command(CMD_POP);
		send_command(CMD_PEEK);
		send_command(CMD_READ_BOT, '0, 10'd0);
		send_command(CMD_READ_TOP, '0, 10'd1023);
		send_command(CMD_CLOSE_DISC);
		send_command(CMD_CLOSE_RET, 32'hFFFF_FFFF);
		// Extreme words and indexed reads
		send_command(CMD_PUSH, 32'hFFFF_FFFF);
		send_command(CMD_PUSH, 32'h0000_0000);
		send_command(CMD_PUSH, 32'hA5A5_5A5A);
		send_command(CMD_PEEK);
		send_command(CMD_READ_BOT, '0, 10'd0);
		send_command(CMD_READ_BOT, '0, 10'd2);
		send_command(CMD_READ_TOP, '0, 10'd0);
		send_command(CMD_READ_TOP, '0, 10'd2);
		send_command(CMD_READ_BOT, '0, 10'd3);
		// Frame with a return word, then one that is discarded
		send_command(CMD_OPEN);
		send_command(CMD_PEEK);
		send_command(CMD_PUSH, 32'h0000_1234);
		send_command(CMD_CLOSE_RET, 32'hDEAD_BEEF);
		send_command(CMD_READ_TOP, '0, 10'd0);
		send_command(CMD_OPEN);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_CLOSE_DISC);
		send_command(CMD_POP);
	endtask

	task automatic test_capacity_limits();
		unwind_to_empty();
		// Zero capacity rejects every push and open
		write_capacity(11'd0);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_OPEN);
		// One word: either a single item or a single return slot
		write_capacity(11'd1);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_OPEN);
		send_command(CMD_POP);
		send_command(CMD_OPEN);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_OPEN);
		send_command(CMD_PEEK);
		send_command(CMD_CLOSE_RET, $urandom);
		send_command(CMD_PEEK);
		send_command(CMD_POP);
		write_capacity(CAP_RESET);
	endtask

	task automatic test_frame_depth();
		unwind_to_empty();
		for (int i = 0; i < FRAME_LIMIT; i++) begin
			send_command(CMD_OPEN);
			send_command(CMD_PUSH, $urandom);
		end
		// One frame too many
		send_command(CMD_OPEN);
		send_command(CMD_READ_BOT, '0, 10'd0);
		for (int i = 0; i < FRAME_LIMIT; i++) begin
			send_command((i % 2) ? CMD_CLOSE_RET : CMD_CLOSE_DISC, $urandom);
			send_command(CMD_PEEK);
		end
		send_command(CMD_CLOSE_RET, $urandom);
		unwind_to_empty();
	endtask

	// Fill a reduced capacity while the sink holds off, so the input backs up
	task automatic test_fill_under_backpressure();
		unwind_to_empty();
		write_capacity(CAP_W'(FILL_CAP));
		long_hold_req = 1'b1;
		send_command(CMD_OPEN);
		repeat (FILL_CAP - 1) send_command(CMD_PUSH, $urandom);
		send_command(CMD_PUSH, $urandom);
		send_command(CMD_OPEN);
		send_command(CMD_READ_BOT, '0, 10'd0);
		send_command(CMD_READ_BOT, '0, INDEX_W'(FILL_CAP - 2));
		send_command(CMD_READ_BOT, '0, INDEX_W'(FILL_CAP - 1));
		send_command(CMD_READ_TOP, '0, 10'd0);
		send_command(CMD_READ_TOP, '0, INDEX_W'(FILL_CAP - 2));
		send_command(CMD_READ_TOP, '0, INDEX_W'(FILL_CAP - 1));
		send_command(CMD_PEEK);
		send_command(CMD_CLOSE_DISC);
		wait_for_responses();
	endtask

	task automatic test_random_traffic(int unsigned n_cmds);
		cmd_t op;
		logic [DATA_W-1:0] word;
		logic [INDEX_W-1:0] idx;
		int unsigned pick;
		int unsigned top_idx;
		repeat (n_cmds) begin
			pick = $urandom_range(99);
			if (cur_items == 0 && pick < 50) op = CMD_PUSH;
			else if (pick < 32) op = CMD_PUSH;
			else if (pick < 46) op = CMD_POP;
			else if (pick < 56) op = CMD_PEEK;
			else if (pick < 66) op = CMD_READ_BOT;
			else if (pick < 76) op = CMD_READ_TOP;
			else if (pick < 86) op = CMD_OPEN;
			else if (pick < 93) op = CMD_CLOSE_DISC;
			else op = CMD_CLOSE_RET;
			if ($urandom_range(9) == 0) word = $urandom_range(1) ? '1 : '0;
			else word = $urandom;
			// Mostly in-range indexes, sometimes anything
			if (cur_items != 0 && $urandom_range(4) != 0) begin
				top_idx = (cur_items - 1 > 1023) ? 1023 : cur_items - 1;
				idx = INDEX_W'($urandom_range(top_idx));
			end else begin
				idx = INDEX_W'($urandom_range(1023));
			end
			send_command(op, word, idx);
		end
	endtask

	initial begin
		cap_setting = CAP_RESET;
		idle_enable = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_commands();
		test_capacity_limits();
		test_frame_depth();
		test_fill_under_backpressure();
		write_capacity(CAP_W'($urandom_range(1, 40)));
		test_random_traffic(100);
		write_capacity(CAP_RESET);
		test_random_traffic(110);
		write_capacity(CAP_W'($urandom_range(1, 2047)));
		test_random_traffic(100);
		// Closing stretch at full rate on both sides
		idle_enable = 1'b0;
		write_capacity(CAP_RESET);
		test_random_traffic(100);
		wait_for_responses();

		$display("Covered %0d commands, %0d results checked: directed, capacity, frame depth,",
			commands_sent, responses_checked);
		$display("stalled fill, random traffic; ok/ovf/unf/rng/fu/fo = %0d/%0d/%0d/%0d/%0d/%0d",
			status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
			status_seen[ST_RANGE], status_seen[ST_FRAME_UNDER], status_seen[ST_FRAME_OVER]);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/fos_pkg.sv
src/fos_ram.sv
src/fos_ctrl.sv
src/fos_dpath.sv
src/framed_operand_stack_unit.sv
bench/framed_operand_stack_unit_tb.sv
